FILE: rtl/crc8_packet_framer_core_assert.svh
// Assertion macros shared by the framer checker.
// Depends on nothing; the including file provides clk and rst.
`ifndef CRC8_PACKET_FRAMER_CORE_ASSERT_SVH
`define CRC8_PACKET_FRAMER_CORE_ASSERT_SVH

// Checked at every edge outside reset.
`define CPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("framer assertion failed");

// Checked at every edge, reset included.
`define CPF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("framer assertion failed");

`endif

FILE: rtl/cpf_pkg.sv
// Package for the CRC-8 packet framer: job types, queue sizing, CRC function.
// Depends on nothing.
`timescale 1ns / 1ps

package cpf_pkg;

  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] SYNC_RESET = 8'hA5;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [1:0] step_t;

  localparam step_t STEP_SYNC   = 2'd0;
  localparam step_t STEP_TYPE   = 2'd1;
  localparam step_t STEP_LEN    = 2'd2;
  localparam step_t STEP_HCHECK = 2'd3;
  localparam step_t STEP_DATA   = 2'd0;
  localparam step_t STEP_DCHECK = 2'd1;

  typedef enum logic [1:0] {
    JOB_HEADER,
    JOB_HEADER_END,
    JOB_DATA,
    JOB_DATA_END
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  sync;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  check;
    logic [31:0] count;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_sts_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/cpf_channels.sv
// Handshake channel interfaces of the CRC-8 packet framer.
// Depends on nothing.
`timescale 1ns / 1ps

interface cpf_cmd_if ();
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] packet_type;
  logic [7:0] packet_length;
  logic [7:0] data_byte;
  modport source (output valid, operation, packet_type, packet_length, data_byte,
                  input ready);
  modport sink (input valid, operation, packet_type, packet_length, data_byte,
                output ready);
endinterface

interface cpf_tx_if ();
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        frame_end;
  logic [31:0] packets_sent;
  modport source (output valid, out_byte, last_of_run, frame_end, packets_sent,
                  input ready);
  modport sink (input valid, out_byte, last_of_run, frame_end, packets_sent,
                output ready);
endinterface

interface cpf_cfg_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/cpf_queue.sv
// Small flip-flop job queue between the framer front and back ends.
// Depends on cpf_pkg.
`timescale 1ns / 1ps

module cpf_queue
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  queue_ctl_t ctl,
  input  job_t       push_job,
  output queue_sts_t sts,
  output job_t       head
);

  job_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign sts.full  = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign sts.empty = (fill == '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (ctl.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({ctl.push, ctl.pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/cpf_front.sv
// Front end: takes command items and sync writes, tracks packet state and CRCs,
// and queues one output job per item that produces bytes. Depends on cpf_pkg.
`timescale 1ns / 1ps

module cpf_front
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cpf_cmd_if.sink    cmd,
  cpf_cfg_if.sink    cfg,
  input  queue_sts_t sts,
  output logic       push,
  output job_t       push_job
);

  logic        sync_value;
  logic [7:0]  sync_reg;
  logic        packet_open;
  logic        packet_open_next;
  logic [7:0]  bytes_left;
  logic [7:0]  bytes_left_next;
  logic [7:0]  header_check;
  logic [7:0]  header_check_next;
  logic [7:0]  payload_check;
  logic [7:0]  payload_check_next;
  logic [31:0] sent_counter;
  logic [31:0] sent_counter_next;
  logic [7:0]  hdr_crc;
  logic [7:0]  pay_crc;
  logic [7:0]  left_dec;
  logic        accept;

  assign cmd.ready  = !sts.full;
  assign cfg.ready  = 1'b1;
  assign accept     = cmd.valid && !sts.full;
  assign sync_value = cfg.valid;

  assign hdr_crc  = crc8_byte(crc8_byte(8'h00, cmd.packet_type), cmd.packet_length);
  assign pay_crc  = crc8_byte(payload_check, cmd.data_byte);
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    packet_open_next   = packet_open;
    bytes_left_next    = bytes_left;
    header_check_next  = header_check;
    payload_check_next = payload_check;
    sent_counter_next  = sent_counter;
    push               = 1'b0;
    push_job.kind      = JOB_HEADER;
    push_job.sync      = sync_reg;
    push_job.b0        = cmd.packet_type;
    push_job.b1        = cmd.packet_length;
    push_job.check     = hdr_crc;
    push_job.count     = sent_counter;
    if (accept) begin
      unique case (cmd.operation)
        OP_START: begin
          if (!packet_open) begin
            push               = 1'b1;
            header_check_next  = hdr_crc;
            payload_check_next = 8'h00;
            if (cmd.packet_length == 8'd0) begin
              push_job.kind     = JOB_HEADER_END;
              sent_counter_next = sent_counter + 32'd1;
            end else begin
              push_job.kind    = JOB_HEADER;
              packet_open_next = 1'b1;
              bytes_left_next  = cmd.packet_length;
            end
          end
        end
        OP_DATA: begin
          if (packet_open) begin
            push               = 1'b1;
            payload_check_next = pay_crc;
            bytes_left_next    = left_dec;
            push_job.b0        = cmd.data_byte;
            push_job.check     = header_check ^ pay_crc;
            if (left_dec != 8'd0) begin
              push_job.kind = JOB_DATA;
            end else begin
              push_job.kind     = JOB_DATA_END;
              sent_counter_next = sent_counter + 32'd1;
              packet_open_next  = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_reg      <= SYNC_RESET;
      packet_open   <= 1'b0;
      bytes_left    <= 8'd0;
      header_check  <= 8'd0;
      payload_check <= 8'd0;
      sent_counter  <= 32'd0;
    end else begin
      if (sync_value) begin
        sync_reg <= cfg.data;
      end
      packet_open   <= packet_open_next;
      bytes_left    <= bytes_left_next;
      header_check  <= header_check_next;
      payload_check <= payload_check_next;
      sent_counter  <= sent_counter_next;
    end
  end

endmodule

FILE: rtl/cpf_back.sv
// Back end: walks each queued job byte by byte into a registered output stage.
// Depends on cpf_pkg.
`timescale 1ns / 1ps

module cpf_back
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  queue_sts_t sts,
  input  job_t       head,
  output logic       pop,
  cpf_tx_if.source   tx
);

  step_t       step;
  step_t       step_next;
  logic        tx_valid;
  logic        tx_valid_next;
  logic [7:0]  tx_byte;
  logic [7:0]  byte_next;
  logic        tx_last;
  logic        last_next;
  logic        tx_end;
  logic        end_next;
  logic [31:0] tx_packets;
  logic [31:0] count_next;
  logic        load;

  assign load = !tx_valid || tx.ready;

  always_comb begin
    byte_next  = head.b0;
    last_next  = 1'b0;
    end_next   = 1'b0;
    count_next = head.count;
    unique case (head.kind)
      JOB_HEADER, JOB_HEADER_END: begin
        unique case (step)
          STEP_SYNC: byte_next = head.sync;
          STEP_TYPE: byte_next = head.b0;
          STEP_LEN: begin
            byte_next = head.b1;
            last_next = (head.kind == JOB_HEADER);
          end
          STEP_HCHECK: begin
            byte_next  = head.check;
            last_next  = 1'b1;
            end_next   = 1'b1;
            count_next = head.count + 32'd1;
          end
        endcase
      end
      JOB_DATA: begin
        byte_next = head.b0;
        last_next = 1'b1;
      end
      JOB_DATA_END: begin
        if (step == STEP_DCHECK) begin
          byte_next  = head.check;
          last_next  = 1'b1;
          end_next   = 1'b1;
          count_next = head.count + 32'd1;
        end else begin
          byte_next = head.b0;
        end
      end
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    step_next     = step;
    tx_valid_next = tx_valid;
    if (load) begin
      tx_valid_next = !sts.empty;
      if (!sts.empty) begin
        if (last_next) begin
          pop       = 1'b1;
          step_next = STEP_SYNC;
        end else begin
          step_next = step + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= STEP_SYNC;
      tx_valid <= 1'b0;
    end else begin
      step     <= step_next;
      tx_valid <= tx_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !sts.empty) begin
      tx_byte    <= byte_next;
      tx_last    <= last_next;
      tx_end     <= end_next;
      tx_packets <= count_next;
    end
  end

  assign tx.valid        = tx_valid;
  assign tx.out_byte     = tx_byte;
  assign tx.last_of_run  = tx_last;
  assign tx.frame_end    = tx_end;
  assign tx.packets_sent = tx_packets;

endmodule

FILE: rtl/crc8_packet_framer_core.sv
// An item that makes bytes is queued; at the queue head its bytes go to the tx output register.
// Throughput: one command item per cycle while the four-job queue has room; the output stage
// sends one byte per cycle unless tx.ready stalls it, so a start sends three or four bytes.
// Reset (rst, synchronous, active high) closes any packet, zeroes CRCs and the packet
// counter, empties the queue and sets the sync byte to 0xA5.
`timescale 1ns / 1ps

module crc8_packet_framer_core
  import cpf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  cpf_cmd_if.sink   cmd,
  cpf_cfg_if.sink   cfg,
  cpf_tx_if.source  tx
);

  queue_ctl_t ctl;
  queue_sts_t sts;
  job_t       push_job;
  job_t       head;

  cpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .sts      (sts),
    .push     (ctl.push),
    .push_job (push_job)
  );

  cpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .push_job (push_job),
    .sts      (sts),
    .head     (head)
  );

  cpf_back u_back (
    .clk  (clk),
    .rst  (rst),
    .sts  (sts),
    .head (head),
    .pop  (ctl.pop),
    .tx   (tx)
  );

endmodule

FILE: rtl/cpf_checker.sv
// Port-level checker for the framer output channel, bound to the top level.
// Depends on crc8_packet_framer_core_assert.svh.
`timescale 1ns / 1ps

`include "crc8_packet_framer_core_assert.svh"

module cpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        tx_valid,
  input logic        tx_ready,
  input logic [7:0]  tx_out_byte,
  input logic        tx_last_of_run,
  input logic        tx_frame_end,
  input logic [31:0] tx_packets_sent
);

  logic [41:0] tx_payload;

  assign tx_payload = {tx_out_byte, tx_last_of_run, tx_frame_end, tx_packets_sent};

  `CPF_ASSERT(a_tx_hold, tx_valid && !tx_ready |=> tx_valid)
  `CPF_ASSERT(a_tx_stable, tx_valid && !tx_ready |=> $stable(tx_payload))
  `CPF_ASSERT(a_end_is_last, tx_valid && tx_frame_end |-> tx_last_of_run)
  `CPF_ASSERT_ALWAYS(a_reset_idle, rst |=> !tx_valid)

endmodule

bind crc8_packet_framer_core cpf_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .tx_valid        (tx.valid),
  .tx_ready        (tx.ready),
  .tx_out_byte     (tx.out_byte),
  .tx_last_of_run  (tx.last_of_run),
  .tx_frame_end    (tx.frame_end),
  .tx_packets_sent (tx.packets_sent)
);

FILE: test/tb_crc8_packet_framer_core.sv
// Self-checking testbench for crc8_packet_framer_core: directed and random command items,
// with every framed byte checked against an in-bench CRC-8 frame predictor.
// Depends on cpf_pkg, the cpf_*_if channel interfaces and the framer core.
`timescale 1ns / 1ps

module tb_crc8_packet_framer_core;
  import cpf_pkg::*;

  typedef struct packed {
    logic       op;
    logic [7:0] ptype;
    logic [7:0] plen;
    logic [7:0] dbyte;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]  txb;
    logic        last_run;
    logic        fend;
    logic [31:0] count;
  } tx_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpf_cmd_if cmd_ch ();
  cpf_cfg_if cfg_ch ();
  cpf_tx_if  tx_ch ();

  crc8_packet_framer_core u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .cfg (cfg_ch),
    .tx  (tx_ch)
  );

  always #4 clk = ~clk;

  cmd_item_t cmd_backlog[$];
  tx_byte_t  tx_bytes_due[$];
  cmd_item_t cmd_on_wire;
  int        err_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      stall_armed = 1'b0;
  logic      stall_done = 1'b0;
  int        stall_left = 0;

  logic [7:0]  sync_cfg = SYNC_RESET;
  logic        pkt_open = 1'b0;
  logic [7:0]  bytes_left = 8'h00;
  logic [7:0]  hdr_crc = 8'h00;
  logic [7:0]  pay_crc = 8'h00;
  logic [31:0] sent_cnt = 32'h0;

  // Bit-serial CRC-8, polynomial 0x07, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return c;
  endfunction

  task automatic due(input logic [7:0] b, input logic l, input logic f, input logic [31:0] n);
    tx_byte_t r;
    r.txb      = b;
    r.last_run = l;
    r.fend     = f;
    r.count    = n;
    tx_bytes_due.push_back(r);
  endtask

  task automatic frame_cmd(input cmd_item_t c);
    if (c.op == OP_START) begin
      if (!pkt_open) begin
        hdr_crc = crc8_step(crc8_step(8'h00, c.ptype), c.plen);
        pay_crc = 8'h00;
        due(sync_cfg, 1'b0, 1'b0, sent_cnt);
        due(c.ptype, 1'b0, 1'b0, sent_cnt);
        if (c.plen == 8'h00) begin
          due(c.plen, 1'b0, 1'b0, sent_cnt);
          sent_cnt = sent_cnt + 32'd1;
          due(hdr_crc, 1'b1, 1'b1, sent_cnt);
        end else begin
          due(c.plen, 1'b1, 1'b0, sent_cnt);
          pkt_open   = 1'b1;
          bytes_left = c.plen;
        end
      end
    end else if (pkt_open) begin
      pay_crc    = crc8_step(pay_crc, c.dbyte);
      bytes_left = bytes_left - 8'd1;
      if (bytes_left != 8'h00) begin
        due(c.dbyte, 1'b1, 1'b0, sent_cnt);
      end else begin
        due(c.dbyte, 1'b0, 1'b0, sent_cnt);
        sent_cnt = sent_cnt + 32'd1;
        due(hdr_crc ^ pay_crc, 1'b1, 1'b1, sent_cnt);
        pkt_open = 1'b0;
      end
    end
  endtask

  task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, e, a);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        frame_cmd(cmd_on_wire);
      end
      if (cmd_ch.valid && !cmd_ch.ready) begin
        cmd_ch.valid <= 1'b1;
      end else if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_on_wire           = cmd_backlog.pop_front();
        cmd_ch.valid         <= 1'b1;
        cmd_ch.operation     <= cmd_on_wire.op;
        cmd_ch.packet_type   <= cmd_on_wire.ptype;
        cmd_ch.packet_length <= cmd_on_wire.plen;
        cmd_ch.data_byte     <= cmd_on_wire.dbyte;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && stall_armed && !stall_done && tx_ch.valid) begin
      stall_done <= 1'b1;
      stall_left <= 300;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    tx_byte_t exp_r;
    if (rst) begin
      tx_ch.ready <= 1'b0;
    end else begin
      if (tx_ch.valid && tx_ch.ready) begin
        if (tx_bytes_due.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual %h", $time, tx_ch.out_byte);
          err_cnt++;
        end else begin
          exp_r = tx_bytes_due.pop_front();
          check_field("out_byte", 32'(exp_r.txb), 32'(tx_ch.out_byte));
          check_field("last_of_run", 32'(exp_r.last_run), 32'(tx_ch.last_of_run));
          check_field("frame_end", 32'(exp_r.fend), 32'(tx_ch.frame_end));
          check_field("packets_sent", exp_r.count, tx_ch.packets_sent);
        end
      end
      if (stall_left > 0) begin
        tx_ch.ready <= 1'b0;
      end else begin
        tx_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_cmd(input logic op, input logic [7:0] t, input logic [7:0] l,
                          input logic [7:0] d);
    cmd_item_t c;
    c.op    = op;
    c.ptype = t;
    c.plen  = l;
    c.dbyte = d;
    cmd_backlog.push_back(c);
  endtask

  task automatic push_data(input int n);
    for (int i = 0; i < n; i++) begin
      push_cmd(OP_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
    end
  endtask

  task automatic queue_traffic(input int n);
    int added;
    int r;
    int len;
    added = 0;
    while (added < n) begin
      r   = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 8);
      if (r < 80) begin
        push_cmd(OP_START, 8'($urandom_range(255)), 8'(len), 8'($urandom_range(255)));
        push_data(len);
        added += len + 1;
      end else if (r < 90) begin
        push_cmd(OP_START, 8'($urandom_range(255)), 8'(len), 8'($urandom_range(255)));
        r = (len > 0) ? $urandom_range(len - 1) : 0;
        push_data(r);
        added += r + 1;
      end else begin
        push_cmd(1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
        added++;
      end
    end
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() > 0 || cmd_ch.valid || tx_bytes_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    sync_cfg = v;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    cmd_ch.valid         = 1'b0;
    cmd_ch.operation     = OP_START;
    cmd_ch.packet_type   = 8'h00;
    cmd_ch.packet_length = 8'h00;
    cmd_ch.data_byte     = 8'h00;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = 8'h00;
    tx_ch.ready          = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 17;
    recv_idle_pct = 79;
    push_cmd(OP_START, 8'hFF, 8'h00, 8'h00);
    push_cmd(OP_DATA, 8'h00, 8'h00, 8'hFF);
    push_cmd(OP_START, 8'h00, 8'h00, 8'hFF);
    push_cmd(OP_START, 8'h3C, 8'h03, 8'h00);
    push_cmd(OP_START, 8'h77, 8'h09, 8'h12);
    push_cmd(OP_DATA, 8'hFF, 8'hFF, 8'h00);
    push_cmd(OP_DATA, 8'h00, 8'h00, 8'hFF);
    push_cmd(OP_DATA, 8'h00, 8'h00, 8'h81);
    push_cmd(OP_START, 8'h01, 8'h01, 8'h00);
    push_cmd(OP_DATA, 8'h00, 8'h00, 8'h7E);
    push_cmd(OP_DATA, 8'h00, 8'h00, 8'h55);
    push_cmd(OP_START, 8'hA5, 8'h02, 8'h00);
    push_cmd(OP_DATA, 8'h00, 8'h00, 8'h80);
    push_cmd(OP_START, 8'h00, 8'h00, 8'h00);
    push_cmd(OP_DATA, 8'h00, 8'h00, 8'h01);
    wait_idle();

    write_sync(8'h00);
    stall_armed = 1'b1;
    queue_traffic(60);
    wait_idle();

    send_idle_pct = 79;
    recv_idle_pct = 17;
    write_sync(8'hFF);
    queue_traffic(60);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_sync(8'($urandom_range(255)));
    push_cmd(OP_START, 8'($urandom_range(255)), 8'hFF, 8'($urandom_range(255)));
    push_data(255);
    queue_traffic(30);
    wait_idle();
    repeat (16) @(posedge clk);

    if (err_cnt == 0 && tx_bytes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cpf_pkg.sv
rtl/cpf_channels.sv
rtl/cpf_queue.sv
rtl/cpf_front.sv
rtl/cpf_back.sv
rtl/crc8_packet_framer_core.sv
rtl/cpf_checker.sv
test/tb_crc8_packet_framer_core.sv
